[rtl/ttdim_pkg.sv]
package ttdim_pkg;

  // gesture phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_START    = 3'd2,
    PH_TAPHOLD  = 3'd3,
    PH_FADE     = 3'd4
  } phase_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_THRESHOLD   = 3'd0,
    REG_DEBOUNCE    = 3'd1,
    REG_TAP         = 3'd2,
    REG_TAP_TIMEOUT = 3'd3,
    REG_FADE_STEP   = 3'd4,
    REG_MIN_BRIGHT  = 3'd5,
    REG_MAX_BRIGHT  = 3'd6
  } reg_idx_t;

  localparam int unsigned CntW   = 16;
  localparam int unsigned BrW    = 8;
  localparam int unsigned InW    = 16;
  localparam int unsigned OutW   = 16;
  localparam int unsigned CfgAw  = 3;
  localparam int unsigned CfgDw  = 16;

  // reset values of the configuration registers
  localparam logic [CntW-1:0] RstThreshold  = 16'd1000;
  localparam logic [CntW-1:0] RstDebounce   = 16'd10;
  localparam logic [CntW-1:0] RstTap        = 16'd200;
  localparam logic [CntW-1:0] RstTapTimeout = 16'd300;
  localparam logic [CntW-1:0] RstFadeStep   = 16'd10;
  localparam logic [BrW-1:0]  RstMinBright  = 8'd0;
  localparam logic [BrW-1:0]  RstMaxBright  = 8'd100;

  // saturating tick counter
  function automatic logic [CntW-1:0] tick_up(input logic [CntW-1:0] c);
    tick_up = (c == {CntW{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

[rtl/touch_tap_hold_dimmer.sv]
// touch tap / hold dimmer: one touch sample word in, one status word out
// path: accepted word held in the input reg, its result word written to the result reg on the update
// throughput: one word per cycle while out_tready holds, set by the single-pass gesture update between the regs
// reset: rst_n synchronous active low; gesture state, timers, light state cleared,
// config registers return to their defaults, no pending words
module touch_tap_hold_dimmer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ttdim_pkg::InW-1:0]   in_tdata,   // [15:0] touch_sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ttdim_pkg::OutW-1:0]  out_tdata,  // [0] light_enable, [8:1] brightness,
                                                  // [9] fade_up, [10] fading,
                                                  // [12:11] pending_taps, [15:13] zero
  input  logic                        cfg_we,
  input  logic [ttdim_pkg::CfgAw-1:0] cfg_addr,
  input  logic [ttdim_pkg::CfgDw-1:0] cfg_wdata
);
  import ttdim_pkg::*;

  // configuration
  logic [CntW-1:0] thresh_r, debounce_r, tap_r, tap_to_r, fade_step_r;
  logic [BrW-1:0]  min_br_r, max_br_r;

  // input stage
  logic            in_valid_r;
  logic [InW-1:0]  sample_r;

  // gesture state
  phase_t          phase_r, phase_nxt;
  logic [1:0]      taps_r, taps_nxt;
  logic            armed_r, armed_nxt;
  logic [CntW-1:0] to_cnt_r, to_cnt_nxt;
  logic [CntW-1:0] ph_cnt_r, ph_cnt_nxt;
  logic [CntW-1:0] fd_cnt_r, fd_cnt_nxt;
  logic            hold_off_r, hold_off_nxt;
  logic            en_r, en_nxt;
  logic [BrW-1:0]  br_r, br_nxt;
  logic            dir_r, dir_nxt;

  // result stage
  logic            out_valid_r;
  logic [OutW-1:0] out_data_r, out_data_nxt;

  logic            adv;
  logic            touched, released;
  logic signed [BrW+1:0] step_b;

  assign adv        = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= RstThreshold;
      debounce_r  <= RstDebounce;
      tap_r       <= RstTap;
      tap_to_r    <= RstTapTimeout;
      fade_step_r <= RstFadeStep;
      min_br_r    <= RstMinBright;
      max_br_r    <= RstMaxBright;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_THRESHOLD:   thresh_r    <= cfg_wdata;
        REG_DEBOUNCE:    debounce_r  <= cfg_wdata;
        REG_TAP:         tap_r       <= cfg_wdata;
        REG_TAP_TIMEOUT: tap_to_r    <= cfg_wdata;
        REG_FADE_STEP:   fade_step_r <= cfg_wdata;
        REG_MIN_BRIGHT:  min_br_r    <= cfg_wdata[BrW-1:0];
        REG_MAX_BRIGHT:  max_br_r    <= cfg_wdata[BrW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_tdata;
    end
  end

  assign touched  = sample_r > thresh_r;
  assign released = sample_r < thresh_r;

  // gesture update for one sample
  always_comb begin
    phase_nxt    = phase_r;
    taps_nxt     = taps_r;
    armed_nxt    = armed_r;
    to_cnt_nxt   = tick_up(to_cnt_r);
    ph_cnt_nxt   = tick_up(ph_cnt_r);
    fd_cnt_nxt   = tick_up(fd_cnt_r);
    hold_off_nxt = hold_off_r;
    en_nxt       = en_r;
    br_nxt       = br_r;
    dir_nxt      = dir_r;
    step_b       = '0;

    // tap timeout, checked on released ticks
    if (released) begin
      if (!armed_r) begin
        if (taps_r != 2'd0) begin
          to_cnt_nxt = '0;
          armed_nxt  = 1'b1;
        end
      end else if (to_cnt_nxt >= tap_to_r) begin
        taps_nxt  = 2'd0;
        armed_nxt = 1'b0;
      end
    end

    case (phase_r)
      PH_IDLE: begin
        if (touched) begin
          ph_cnt_nxt = '0;
          phase_nxt  = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (touched) begin
          if (ph_cnt_nxt >= debounce_r) phase_nxt = PH_START;
        end else begin
          phase_nxt = PH_IDLE;
          taps_nxt  = 2'd0;
        end
      end
      PH_START: begin
        ph_cnt_nxt = '0;
        phase_nxt  = PH_TAPHOLD;
      end
      PH_TAPHOLD: begin
        if (touched) begin
          if (ph_cnt_nxt >= tap_r) phase_nxt = PH_FADE;
        end else begin
          // second tap toggles the light when it is on and lit, or off and dark
          if (taps_nxt != 2'd0) begin
            if (!en_r && br_r == '0) begin
              en_nxt = 1'b1;
              br_nxt = max_br_r;
            end else if (en_r && br_r != '0) begin
              en_nxt = 1'b0;
              br_nxt = '0;
            end
            taps_nxt = 2'd0;
          end else begin
            taps_nxt = 2'd1;
          end
          phase_nxt = PH_IDLE;
        end
      end
      PH_FADE: begin
        if (taps_nxt != 2'd1) begin
          phase_nxt = PH_IDLE;
        end else begin
          if (touched) begin
            // bounce at the limits, then step once per interval
            if (br_r >= max_br_r) dir_nxt = 1'b0;
            if (br_r <= min_br_r) dir_nxt = 1'b1;
            if (!hold_off_r) begin
              if (dir_nxt) begin
                en_nxt = 1'b1;
                step_b = $signed({2'b00, br_r}) + 10'sd1;
              end else begin
                step_b = $signed({2'b00, br_r}) - 10'sd1;
              end
              if (step_b > $signed({2'b00, max_br_r})) step_b = $signed({2'b00, max_br_r});
              if (step_b < $signed({2'b00, min_br_r})) step_b = $signed({2'b00, min_br_r});
              br_nxt       = step_b[BrW-1:0];
              fd_cnt_nxt   = '0;
              hold_off_nxt = 1'b1;
            end
          end else begin
            dir_nxt   = !dir_r;
            phase_nxt = PH_IDLE;
            taps_nxt  = 2'd0;
          end
          if (hold_off_nxt && fd_cnt_nxt >= fade_step_r) hold_off_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    out_data_nxt = {3'b000, taps_nxt, (phase_nxt == PH_FADE), dir_nxt, br_nxt, en_nxt};
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      taps_r     <= 2'd0;
      armed_r    <= 1'b0;
      to_cnt_r   <= '0;
      ph_cnt_r   <= '0;
      fd_cnt_r   <= '0;
      hold_off_r <= 1'b0;
      en_r       <= 1'b0;
      br_r       <= '0;
      dir_r      <= 1'b0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      taps_r     <= taps_nxt;
      armed_r    <= armed_nxt;
      to_cnt_r   <= to_cnt_nxt;
      ph_cnt_r   <= ph_cnt_nxt;
      fd_cnt_r   <= fd_cnt_nxt;
      hold_off_r <= hold_off_nxt;
      en_r       <= en_nxt;
      br_r       <= br_nxt;
      dir_r      <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
    taps_r != 2'd3) else $error("tap count out of range");

  a_adv_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r) else $error("result word missing after update");

  a_start_to_taphold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_START) |=> phase_r == PH_TAPHOLD)
    else $error("start phase did not move to tap or hold");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(phase_r) && $stable(br_r) && $stable(taps_r)))
    else $error("gesture state changed without a word");

endmodule
